// File: design/ogru_pkg.sv
// shared constants, types and helper functions of the occupancy grid ray update
package ogru_pkg;

	// grid geometry
	localparam int GRID_WIDTH  = 1024;
	localparam int GRID_HEIGHT = 1024;
	localparam int CELLS       = GRID_WIDTH * GRID_HEIGHT;
	localparam int ADDR_W      = $clog2(CELLS);
	localparam int XW          = $clog2(GRID_WIDTH);
	localparam int YW          = $clog2(GRID_HEIGHT);

	// field widths
	localparam int CRD_W  = 12;
	localparam int VAL_W  = 8;
	localparam int LEN_W  = 12;
	localparam int ERR_W  = 16;
	localparam int ACT_W  = 2;
	localparam int CLS_W  = 2;
	localparam int IDX_W  = 2;
	localparam int FLAG_W = 4;

	typedef logic [ADDR_W-1:0]        addr_t;
	typedef logic signed [CRD_W-1:0]  crd_t;
	typedef logic [VAL_W-1:0]         val_t;
	typedef logic [FLAG_W-1:0]        flags_t;

	// action codes
	localparam logic [ACT_W-1:0] ACT_FREE   = 2'd0;
	localparam logic [ACT_W-1:0] ACT_OCCUPY = 2'd1;
	localparam logic [ACT_W-1:0] ACT_READ   = 2'd2;
	localparam logic [ACT_W-1:0] ACT_CLEAR  = 2'd3;

	// cell class codes
	localparam logic [CLS_W-1:0] CLASS_UNKNOWN  = 2'd0;
	localparam logic [CLS_W-1:0] CLASS_OCCUPIED = 2'd1;
	localparam logic [CLS_W-1:0] CLASS_FREE     = 2'd2;

	// configuration register indexes
	localparam logic [IDX_W-1:0] REG_FREE_LIMIT     = 2'd0;
	localparam logic [IDX_W-1:0] REG_OCCUPIED_LIMIT = 2'd1;
	localparam logic [IDX_W-1:0] REG_UNKNOWN_LEVEL  = 2'd2;

	// configuration reset values and grid fill level
	localparam val_t FREE_LIMIT_RST     = 8'd137;
	localparam val_t OCCUPIED_LIMIT_RST = 8'd117;
	localparam val_t UNKNOWN_LEVEL_RST  = 8'd127;
	localparam val_t CLEAR_LEVEL        = 8'd127;

	// flag bit positions
	localparam int FLAG_LEFT   = 0;
	localparam int FLAG_TOP    = 1;
	localparam int FLAG_RIGHT  = 2;
	localparam int FLAG_BOTTOM = 3;

	// controller to datapath commands
	typedef struct packed {
		logic clr;
		logic load;
		logic step;
		logic rd_end;
		logic resp;
	} cmd_t;

	// datapath to controller status
	typedef struct packed {
		logic clr_last;
		logic cnt_zero;
		logic cnt_one;
	} sts_t;

	// linear memory address of an on-grid cell
	function automatic addr_t cell_addr(input crd_t x, input crd_t y);
		addr_t row;
		row = ADDR_W'(y[YW-1:0]);
		return row * ADDR_W'(GRID_WIDTH) + ADDR_W'(x[XW-1:0]);
	endfunction

	// out-of-bounds flags raised by one cell
	function automatic flags_t cell_bounds(input crd_t x, input crd_t y);
		flags_t f;
		f              = '0;
		f[FLAG_LEFT]   = x[CRD_W-1];
		f[FLAG_TOP]    = y[CRD_W-1];
		f[FLAG_RIGHT]  = !x[CRD_W-1] && ($unsigned(x) >= CRD_W'(GRID_WIDTH));
		f[FLAG_BOTTOM] = !y[CRD_W-1] && ($unsigned(y) >= CRD_W'(GRID_HEIGHT));
		return f;
	endfunction

endpackage

// File: design/ogru_ctrl.sv
// controller state machine of the occupancy grid ray update
module ogru_ctrl (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  logic [ogru_pkg::ACT_W-1:0]   action,
	input  ogru_pkg::sts_t               sts,
	output ogru_pkg::cmd_t               cmd,
	output logic                         busy,
	output logic                         done
);
	import ogru_pkg::*;

	localparam logic [2:0] ST_CLEAR  = 3'd0;
	localparam logic [2:0] ST_IDLE   = 3'd1;
	localparam logic [2:0] ST_WALK   = 3'd2;
	localparam logic [2:0] ST_DRAIN1 = 3'd3;
	localparam logic [2:0] ST_DRAIN2 = 3'd4;
	localparam logic [2:0] ST_READ   = 3'd5;
	localparam logic [2:0] ST_RESP   = 3'd6;

	logic [2:0] state_q;
	logic [2:0] state_nx;
	logic       done_q;

	// command decode
	always_comb begin
		cmd        = '0;
		cmd.clr    = (state_q == ST_CLEAR);
		cmd.load   = (state_q == ST_IDLE) && start;
		cmd.step   = (state_q == ST_WALK) && !sts.cnt_zero;
		cmd.rd_end = (state_q == ST_READ);
		cmd.resp   = (state_q == ST_RESP);
	end

	// next state
	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			ST_CLEAR: begin
				if (sts.clr_last)
					state_nx = ST_IDLE;
			end
			ST_IDLE: begin
				if (start)
					state_nx = (action == ACT_FREE) ? ST_WALK : ST_DRAIN1;
			end
			ST_WALK: begin
				if (sts.cnt_zero || sts.cnt_one)
					state_nx = ST_DRAIN1;
			end
			ST_DRAIN1: state_nx = ST_DRAIN2;
			ST_DRAIN2: state_nx = ST_READ;
			ST_READ:   state_nx = ST_RESP;
			ST_RESP:   state_nx = ST_IDLE;
			default:   state_nx = ST_IDLE;
		endcase
	end

	// state and result strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_nx;
			done_q  <= (state_q == ST_RESP);
		end
	end

	assign busy = (state_q != ST_IDLE);
	assign done = done_q;

endmodule

// File: design/ogru_dp.sv
// datapath of the occupancy grid ray update: line walker, grid memory, flags
module ogru_dp (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_we,
	input  logic [ogru_pkg::IDX_W-1:0]   cfg_index,
	input  ogru_pkg::val_t               cfg_data,
	input  logic [ogru_pkg::ACT_W-1:0]   action,
	input  ogru_pkg::crd_t               start_x,
	input  ogru_pkg::crd_t               start_y,
	input  ogru_pkg::crd_t               end_x,
	input  ogru_pkg::crd_t               end_y,
	input  ogru_pkg::cmd_t               cmd,
	output ogru_pkg::sts_t               sts,
	output ogru_pkg::val_t               cell_value,
	output logic [ogru_pkg::CLS_W-1:0]   cell_class,
	output ogru_pkg::flags_t             flags
);
	import ogru_pkg::*;

	// configuration
	val_t free_lim_q, occ_lim_q, unk_lvl_q;

	// walker state
	crd_t                    x_q, y_q, ex_q, ey_q;
	logic signed [ERR_W-1:0] e_q;
	logic [LEN_W-1:0]        cnt_q, adx_q, ady_q;
	logic                    xneg_q, yneg_q, majx_q, occ_q;

	// pipeline and memory
	logic   valid_s1, valid_s2;
	addr_t  addr_s2;
	val_t   rdata_s2;
	flags_t flags_q;
	addr_t  clr_q;
	val_t   value_q;
	logic [CLS_W-1:0] class_q;
	val_t   grid_mem [CELLS];

	// setup arithmetic
	logic signed [CRD_W:0] dxs, dys;
	logic [LEN_W-1:0]      adx, ady, major;
	logic                  majx;

	// step arithmetic
	logic signed [ERR_W-1:0] two_dx, two_dy, e_add, e_nx;
	crd_t                    x_inc, y_inc, x_nx, y_nx;
	logic                    at_end;

	// cell stage
	flags_t bounds_s1, flags_nx;
	addr_t  rd_addr;
	val_t   wdata;
	logic   end_on;

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			free_lim_q <= FREE_LIMIT_RST;
			occ_lim_q  <= OCCUPIED_LIMIT_RST;
			unk_lvl_q  <= UNKNOWN_LEVEL_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_FREE_LIMIT:     free_lim_q <= cfg_data;
				REG_OCCUPIED_LIMIT: occ_lim_q  <= cfg_data;
				REG_UNKNOWN_LEVEL:  unk_lvl_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	// deltas and major axis of a new ray
	always_comb begin
		dxs   = {end_x[CRD_W-1], end_x} - {start_x[CRD_W-1], start_x};
		dys   = {end_y[CRD_W-1], end_y} - {start_y[CRD_W-1], start_y};
		adx   = dxs[CRD_W] ? LEN_W'(-dxs) : LEN_W'(dxs);
		ady   = dys[CRD_W] ? LEN_W'(-dys) : LEN_W'(dys);
		majx  = (adx > ady);
		major = majx ? adx : ady;
	end

	// one bresenham step
	always_comb begin
		two_dx = $signed(ERR_W'({adx_q, 1'b0}));
		two_dy = $signed(ERR_W'({ady_q, 1'b0}));
		x_inc  = xneg_q ? x_q - CRD_W'(1) : x_q + CRD_W'(1);
		y_inc  = yneg_q ? y_q - CRD_W'(1) : y_q + CRD_W'(1);
		if (majx_q) begin
			e_add = e_q + two_dy;
			x_nx  = x_inc;
			if (!e_add[ERR_W-1]) begin
				y_nx = y_inc;
				e_nx = e_add - two_dx;
			end else begin
				y_nx = y_q;
				e_nx = e_add;
			end
		end else begin
			e_add = e_q + two_dx;
			y_nx  = y_inc;
			if (!e_add[ERR_W-1]) begin
				x_nx = x_inc;
				e_nx = e_add - two_dy;
			end else begin
				x_nx = x_q;
				e_nx = e_add;
			end
		end
		at_end = (x_nx == ex_q) && (y_nx == ey_q);
	end

	// walker registers
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			ex_q   <= end_x;
			ey_q   <= end_y;
			x_q    <= (action == ACT_OCCUPY) ? end_x : start_x;
			y_q    <= (action == ACT_OCCUPY) ? end_y : start_y;
			adx_q  <= adx;
			ady_q  <= ady;
			xneg_q <= dxs[CRD_W] || (dxs == '0);
			yneg_q <= dys[CRD_W] || (dys == '0);
			majx_q <= majx;
			e_q    <= -$signed(ERR_W'(major));
			cnt_q  <= (action == ACT_FREE) ? major : '0;
			occ_q  <= (action == ACT_OCCUPY);
		end else if (cmd.step) begin
			x_q   <= x_nx;
			y_q   <= y_nx;
			e_q   <= e_nx;
			cnt_q <= cnt_q - LEN_W'(1);
		end
	end

	// cell stage: bounds check and flag merge
	always_comb begin
		bounds_s1 = cell_bounds(x_q, y_q);
		flags_nx  = flags_q | bounds_s1;
		rd_addr   = cmd.rd_end ? cell_addr(ex_q, ey_q) : cell_addr(x_q, y_q);
	end

	// pipeline valids, flags and clear sweep counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			flags_q  <= '0;
			clr_q    <= '0;
		end else begin
			valid_s1 <= cmd.load ? (action == ACT_OCCUPY) : (cmd.step && !at_end);
			valid_s2 <= valid_s1 && (flags_nx == '0);
			priority if (cmd.load && (action == ACT_CLEAR))
				flags_q <= '0;
			else if (valid_s1)
				flags_q <= flags_nx;
			if (cmd.clr)
				clr_q <= clr_q + ADDR_W'(1);
		end
	end

	// write address follows the read in the next cycle
	always_ff @(posedge clk) begin
		addr_s2 <= rd_addr;
	end

	// saturating update of the cell just read
	always_comb begin
		if (occ_q)
			wdata = (rdata_s2 > occ_lim_q) ? rdata_s2 - VAL_W'(1) : rdata_s2;
		else
			wdata = (rdata_s2 < free_lim_q) ? rdata_s2 + VAL_W'(1) : rdata_s2;
	end

	// grid memory: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (cmd.clr)
			grid_mem[clr_q] <= CLEAR_LEVEL;
		else if (valid_s2)
			grid_mem[addr_s2] <= wdata;
		rdata_s2 <= grid_mem[rd_addr];
	end

	// result value and class of the end cell
	assign end_on = (cell_bounds(ex_q, ey_q) == '0);

	always_ff @(posedge clk) begin
		if (cmd.resp) begin
			value_q <= end_on ? rdata_s2 : '0;
			priority if (!end_on || (rdata_s2 == unk_lvl_q))
				class_q <= CLASS_UNKNOWN;
			else if (rdata_s2 < unk_lvl_q)
				class_q <= CLASS_OCCUPIED;
			else
				class_q <= CLASS_FREE;
		end
	end

	// status
	always_comb begin
		sts          = '0;
		sts.clr_last = (clr_q == ADDR_W'(CELLS - 1));
		sts.cnt_zero = (cnt_q == '0);
		sts.cnt_one  = (cnt_q == LEN_W'(1));
	end

	assign cell_value = value_q;
	assign cell_class = class_q;
	assign flags      = flags_q;

endmodule

// File: design/occupancy_grid_ray_update_top.sv
// top level of the occupancy grid ray update
// occupy, read and clear go from the accepting edge through the drain, read and
// response states to done; a free ray first walks its major-axis length L
// (one grid read-modify-write per cycle through the walker and memory pipeline).
// start is taken again in the cycle that shows done; results cannot be stalled.
// reset clears flags and loads the configuration reset values, then the grid is swept to 127
// over all GRID_WIDTH*GRID_HEIGHT (1048576) cells with busy high.
module occupancy_grid_ray_update_top (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_we,
	input  logic [ogru_pkg::IDX_W-1:0]   cfg_index,
	input  ogru_pkg::val_t               cfg_data,
	input  logic                         start,
	output logic                         busy,
	input  logic [ogru_pkg::ACT_W-1:0]   action,
	input  ogru_pkg::crd_t               start_x,
	input  ogru_pkg::crd_t               start_y,
	input  ogru_pkg::crd_t               end_x,
	input  ogru_pkg::crd_t               end_y,
	output logic                         done,
	output ogru_pkg::val_t               cell_value,
	output logic [ogru_pkg::CLS_W-1:0]   cell_class,
	output logic                         left_out,
	output logic                         top_out,
	output logic                         right_out,
	output logic                         bottom_out
);
	import ogru_pkg::*;

	cmd_t   cmd;
	sts_t   sts;
	flags_t flags;

	// controller
	ogru_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.action (action),
		.sts    (sts),
		.cmd    (cmd),
		.busy   (busy),
		.done   (done)
	);

	// datapath
	ogru_dp u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.action     (action),
		.start_x    (start_x),
		.start_y    (start_y),
		.end_x      (end_x),
		.end_y      (end_y),
		.cmd        (cmd),
		.sts        (sts),
		.cell_value (cell_value),
		.cell_class (cell_class),
		.flags      (flags)
	);

	// flag outputs
	assign left_out   = flags[FLAG_LEFT];
	assign top_out    = flags[FLAG_TOP];
	assign right_out  = flags[FLAG_RIGHT];
	assign bottom_out = flags[FLAG_BOTTOM];

endmodule

// File: design/ogru_checker.sv
// port-level checker of the occupancy grid ray update and its bind
module ogru_checker (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         start,
	input logic                         busy,
	input logic                         done,
	input logic [ogru_pkg::CLS_W-1:0]   cell_class,
	input logic                         left_out,
	input logic                         top_out,
	input logic                         right_out,
	input logic                         bottom_out
);
	import ogru_pkg::*;

	// an accepted transaction keeps the block busy in the next cycle
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("accepted transaction did not raise busy");

	// a result is shown only once the block is ready again
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result strobe while busy");

	// result strobe is a single-cycle pulse
	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("result strobe lasted more than one cycle");

	// flags only move while a transaction is in progress
	a_flags_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!busy && !start |=> $stable({left_out, top_out, right_out, bottom_out}))
		else $error("flags changed while idle");

	// class code is always one of the three classes
	a_class_code: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (cell_class == CLASS_UNKNOWN || cell_class == CLASS_OCCUPIED
			|| cell_class == CLASS_FREE))
		else $error("invalid cell class on result");

endmodule

bind occupancy_grid_ray_update_top ogru_checker u_ogru_checker (.*);

// File: test/tb_occupancy_grid_ray_update_top.sv
// testbench for the occupancy grid ray update: commands checked against a grid scoreboard
module tb_occupancy_grid_ray_update_top;
	import ogru_pkg::*;

	// register settings and sender idle rate of each random phase, -1 picks a random value
	localparam int PHASES = 5;
	localparam int PHASE_ITEMS = 112;
	localparam int PHASE_FREE [PHASES] = '{137, 255, 0, -1, 134};
	localparam int PHASE_OCC  [PHASES] = '{117, 0, 255, -1, 121};
	localparam int PHASE_UNK  [PHASES] = '{127, 0, 255, -1, 128};
	localparam int PHASE_IDLE [PHASES] = '{0, 79, 24, 0, 79};

	// expected contents of one result transaction
	typedef struct {
		val_t             value;
		logic [CLS_W-1:0] cls;
		flags_t           flags;
	} cell_report_t;

	// coordinate regions used by the random commands
	typedef enum int {ZONE_CENTER, ZONE_LOW, ZONE_HIGH, ZONE_ANY} zone_e;

	// grid state tracker and result checker
	class grid_scoreboard;
		val_t         cells [int unsigned];
		flags_t       flags;
		val_t         free_limit;
		val_t         occupied_limit;
		val_t         unknown_level;
		cell_report_t reports_due [$];
		int           failures;
		int           reports;
		int           action_count [4];

		function new();
			flags = '0;
			free_limit = FREE_LIMIT_RST;
			occupied_limit = OCCUPIED_LIMIT_RST;
			unknown_level = UNKNOWN_LEVEL_RST;
			failures = 0;
			reports = 0;
			foreach (action_count[i])
				action_count[i] = 0;
		endfunction

		function void set_reg(logic [IDX_W-1:0] idx, val_t v);
			case (idx)
				REG_FREE_LIMIT: begin
					free_limit = v;
				end
				REG_OCCUPIED_LIMIT: begin
					occupied_limit = v;
				end
				REG_UNKNOWN_LEVEL: begin
					unknown_level = v;
				end
				default: begin
				end
			endcase
		endfunction

		function bit inside_grid(int x, int y);
			return x >= 0 && y >= 0 && x < GRID_WIDTH && y < GRID_HEIGHT;
		endfunction

		// untouched cells still hold the clear level
		function val_t cell_at(int x, int y);
			int unsigned a;
			a = y * GRID_WIDTH + x;
			if (cells.exists(a))
				return cells[a];
			return CLEAR_LEVEL;
		endfunction

		// bounds flags first, then a saturating step unless any flag is up
		function void bump_cell(int x, int y, bit lower);
			int unsigned a;
			val_t v;
			if (x < 0) flags[FLAG_LEFT] = 1'b1;
			if (y < 0) flags[FLAG_TOP] = 1'b1;
			if (x >= GRID_WIDTH) flags[FLAG_RIGHT] = 1'b1;
			if (y >= GRID_HEIGHT) flags[FLAG_BOTTOM] = 1'b1;
			if (flags != '0 || !inside_grid(x, y))
				return;
			a = y * GRID_WIDTH + x;
			v = cell_at(x, y);
			if (lower) begin
				if (v > occupied_limit)
					cells[a] = v - 8'd1;
			end else if (v < free_limit) begin
				cells[a] = v + 8'd1;
			end
		endfunction

		// bresenham walk, the end cell itself is skipped
		function void walk_ray(int x0, int y0, int x1, int y1);
			int dx, dy, ux, uy, x, y, e;
			dx = x1 - x0;
			dy = y1 - y0;
			ux = dx > 0 ? 1 : -1;
			uy = dy > 0 ? 1 : -1;
			x = x0;
			y = y0;
			if (dx < 0) dx = -dx;
			if (dy < 0) dy = -dy;
			if (dx > dy) begin
				e = -dx;
				for (int i = 0; i < dx; i++) begin
					x += ux;
					e += 2 * dy;
					if (e >= 0) begin
						y += uy;
						e -= 2 * dx;
					end
					if (x != x1 || y != y1) bump_cell(x, y, 1'b0);
				end
			end else begin
				e = -dy;
				for (int i = 0; i < dy; i++) begin
					y += uy;
					e += 2 * dx;
					if (e >= 0) begin
						x += ux;
						e -= 2 * dy;
					end
					if (x != x1 || y != y1) bump_cell(x, y, 1'b0);
				end
			end
		endfunction

		// apply an accepted command and queue the report it should produce
		function void accept_command(logic [ACT_W-1:0] act, crd_t sx, crd_t sy, crd_t ex, crd_t ey);
			int x1, y1;
			cell_report_t r;
			x1 = int'(ex);
			y1 = int'(ey);
			case (act)
				ACT_FREE: begin
					walk_ray(int'(sx), int'(sy), x1, y1);
				end
				ACT_OCCUPY: begin
					bump_cell(x1, y1, 1'b1);
				end
				ACT_CLEAR: begin
					flags = '0;
				end
				default: begin
				end
			endcase
			r.value = '0;
			r.cls = CLASS_UNKNOWN;
			if (inside_grid(x1, y1)) begin
				r.value = cell_at(x1, y1);
				if (r.value == unknown_level)
					r.cls = CLASS_UNKNOWN;
				else if (r.value < unknown_level)
					r.cls = CLASS_OCCUPIED;
				else
					r.cls = CLASS_FREE;
			end
			r.flags = flags;
			reports_due.push_back(r);
			action_count[act]++;
		endfunction

		function void check_field(string name, logic [7:0] want, logic [7:0] got);
			if (got !== want) begin
				$error("%s expected %0d got %0d", name, want, got);
				failures++;
			end
		endfunction

		// compare a result transaction with the oldest queued report
		function void compare_report(val_t value, logic [CLS_W-1:0] cls,
				logic lo, logic to, logic ro, logic bo);
			cell_report_t r;
			if (reports_due.size() == 0) begin
				$error("result transaction with no command outstanding");
				failures++;
				return;
			end
			r = reports_due.pop_front();
			reports++;
			check_field("cell_value", r.value, value);
			check_field("cell_class", 8'(r.cls), 8'(cls));
			check_field("left_out", 8'(r.flags[FLAG_LEFT]), 8'(lo));
			check_field("top_out", 8'(r.flags[FLAG_TOP]), 8'(to));
			check_field("right_out", 8'(r.flags[FLAG_RIGHT]), 8'(ro));
			check_field("bottom_out", 8'(r.flags[FLAG_BOTTOM]), 8'(bo));
		endfunction
	endclass

	logic             clk = 1'b0;
	logic             arst_n = 1'b0;
	logic             cfg_we = 1'b0;
	logic [IDX_W-1:0] cfg_index = '0;
	val_t             cfg_data = '0;
	logic             start = 1'b0;
	logic             busy;
	logic [ACT_W-1:0] action = ACT_READ;
	crd_t             start_x = '0;
	crd_t             start_y = '0;
	crd_t             end_x = '0;
	crd_t             end_y = '0;
	logic             done;
	val_t             cell_value;
	logic [CLS_W-1:0] cell_class;
	logic             left_out;
	logic             top_out;
	logic             right_out;
	logic             bottom_out;

	grid_scoreboard sb = new();
	int idle_pct = 0;

	occupancy_grid_ray_update_top uut (.*);

	// clock
	always #1 clk = ~clk;

	// result monitor
	always @(posedge clk) begin
		if (arst_n && done)
			sb.compare_report(cell_value, cell_class, left_out, top_out, right_out, bottom_out);
	end

	// one command transaction, with random idle cycles ahead of it
	task automatic issue(logic [ACT_W-1:0] act, crd_t sx, crd_t sy, crd_t ex, crd_t ey);
		@(negedge clk);
		while ($urandom_range(99) < idle_pct) begin
			start = 1'b0;
			@(negedge clk);
		end
		start = 1'b1;
		action = act;
		start_x = sx;
		start_y = sy;
		end_x = ex;
		end_y = ey;
		@(posedge clk);
		while (busy) @(posedge clk);
		sb.accept_command(act, sx, sy, ex, ey);
	endtask

	// stop sending and wait for every outstanding result
	task automatic settle();
		@(negedge clk);
		start = 1'b0;
		while (sb.reports_due.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic write_reg(logic [IDX_W-1:0] idx, val_t v);
		@(negedge clk);
		cfg_we = 1'b1;
		cfg_index = idx;
		cfg_data = v;
		@(posedge clk);
		sb.set_reg(idx, v);
		@(negedge clk);
		cfg_we = 1'b0;
	endtask

	function automatic zone_e pick_zone();
		int r;
		r = $urandom_range(99);
		if (r < 60) return ZONE_CENTER;
		if (r < 77) return ZONE_LOW;
		if (r < 94) return ZONE_HIGH;
		return ZONE_ANY;
	endfunction

	// small windows keep rays short and revisit cells, edge windows cross the border
	function automatic crd_t coord_in(zone_e z, int span);
		case (z)
			ZONE_CENTER: return crd_t'(40 + $urandom_range(11));
			ZONE_LOW:    return crd_t'(int'($urandom_range(13)) - 3);
			ZONE_HIGH:   return crd_t'(span - 8 + int'($urandom_range(13)));
			default:     return crd_t'($urandom_range(4095));
		endcase
	endfunction

	// random command, clears favored while flags block updates
	task automatic random_command();
		int r;
		zone_e zx, zy;
		logic [ACT_W-1:0] act;
		crd_t sx, sy, ex, ey;
		r = $urandom_range(99);
		if (sb.flags != '0 && $urandom_range(99) < 40)
			act = ACT_CLEAR;
		else if (r < 50)
			act = ACT_FREE;
		else if (r < 75)
			act = ACT_OCCUPY;
		else if (r < 88)
			act = ACT_READ;
		else
			act = ACT_CLEAR;
		zx = pick_zone();
		zy = pick_zone();
		sx = coord_in(zx, GRID_WIDTH);
		ex = coord_in(zx, GRID_WIDTH);
		sy = coord_in(zy, GRID_HEIGHT);
		ey = coord_in(zy, GRID_HEIGHT);
		r = $urandom_range(99);
		if (r < 5) begin
			sx = coord_in(pick_zone(), GRID_WIDTH);
			sy = coord_in(pick_zone(), GRID_HEIGHT);
		end else if (r < 8) begin
			sx = ex;
			sy = ey;
		end
		issue(act, sx, sy, ex, ey);
	endtask

	// stimulus
	initial begin
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		// grid sweep after reset
		@(posedge clk);
		while (busy) @(posedge clk);

		// directed commands with the reset register values
		issue(ACT_READ, 0, 0, 0, 0);
		issue(ACT_READ, 2047, -2048, 1023, 1023);
		issue(ACT_READ, -2048, 2047, -2048, 2047);
		issue(ACT_READ, 0, 0, 2047, -2048);
		issue(ACT_FREE, 3, 3, 3, 3);
		issue(ACT_FREE, 0, 0, 5, 2);
		issue(ACT_FREE, 3, 0, 1, 7);
		issue(ACT_FREE, 5, 5, 0, 0);
		issue(ACT_READ, 0, 0, 1, 0);
		issue(ACT_OCCUPY, 0, 0, 2, 1);
		issue(ACT_OCCUPY, 0, 0, 2, 1);
		// right flag raised partway along the ray
		issue(ACT_FREE, 1020, 3, 1030, 3);
		issue(ACT_READ, 0, 0, 1023, 3);
		issue(ACT_CLEAR, 0, 0, 1022, 3);
		// off-grid end cell: not bounds checked on a free ray, but flagged on occupy
		issue(ACT_FREE, 10, 10, 10, -1);
		issue(ACT_OCCUPY, 0, 0, -1, 1024);
		// updates skipped while flags are up
		issue(ACT_FREE, 0, 0, 4, 0);
		issue(ACT_CLEAR, 0, 0, 1, 0);
		issue(ACT_FREE, 2047, 2047, -2048, -2048);
		issue(ACT_CLEAR, 0, 0, 0, 0);
		issue(ACT_FREE, -2048, 0, 3, 0);
		issue(ACT_CLEAR, 0, 0, 0, 0);
		issue(ACT_OCCUPY, 0, 0, 0, 1023);
		issue(ACT_FREE, 0, -2048, 0, 2047);
		issue(ACT_CLEAR, 0, 0, 0, 1023);
		settle();

		// random phases, registers rewritten while idle
		for (int p = 0; p < PHASES; p++) begin
			write_reg(REG_FREE_LIMIT,
				PHASE_FREE[p] < 0 ? val_t'($urandom_range(255)) : val_t'(PHASE_FREE[p]));
			write_reg(REG_OCCUPIED_LIMIT,
				PHASE_OCC[p] < 0 ? val_t'($urandom_range(255)) : val_t'(PHASE_OCC[p]));
			write_reg(REG_UNKNOWN_LEVEL,
				PHASE_UNK[p] < 0 ? val_t'($urandom_range(255)) : val_t'(PHASE_UNK[p]));
			idle_pct = PHASE_IDLE[p];
			for (int i = 0; i < PHASE_ITEMS; i++)
				random_command();
			settle();
		end

		$display("covered %0d free rays, %0d occupy, %0d read and %0d clear transactions",
			sb.action_count[ACT_FREE], sb.action_count[ACT_OCCUPY],
			sb.action_count[ACT_READ], sb.action_count[ACT_CLEAR]);
		$display("%0d results compared over %0d register settings, sender idle 0/24/79 percent",
			sb.reports, PHASES + 1);
		if (sb.failures == 0)
			$display("[occupancy_grid_ray_update_top] OK");
		else
			$display("[occupancy_grid_ray_update_top] ERROR");
		$finish;
	end

	// watchdog, allows for the grid sweep after reset and the long rays
	initial begin
		#40000000;
		$display("[occupancy_grid_ray_update_top] ERROR");
		$finish;
	end

endmodule
